### rtl/ldtw_pkg.sv
// Package for the two-wire LED driver writer.
// Holds the channel word types, register map and sequencer constants.
// No dependencies.
package ldtw_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] address;
      logic [7:0] payload;
   } req_word_type;

   typedef struct packed {
      logic clock_pin;
      logic data_pin;
      logic busy_res;
      logic rejected;
   } rsp_word_type;

   localparam int unsigned CSR_ADDR_BITS = 4;

   localparam logic [1:0] REG_SHORT_WAIT      = 2'd0;
   localparam logic [1:0] REG_LONG_WAIT       = 2'd1;
   localparam logic [1:0] REG_MODE_COMMAND    = 2'd2;
   localparam logic [1:0] REG_DISPLAY_COMMAND = 2'd3;

   localparam logic [7:0] SHORT_WAIT_RESET      = 8'd3;
   localparam logic [7:0] LONG_WAIT_RESET       = 8'd10;
   localparam logic [7:0] MODE_COMMAND_RESET    = 8'h44;
   localparam logic [7:0] DISPLAY_COMMAND_RESET = 8'h8C;

   localparam logic       MODE_TICK    = 1'b0;
   localparam logic       MODE_REQUEST = 1'b1;

   localparam logic [1:0] FRAME_MODE    = 2'd0;
   localparam logic [1:0] FRAME_DATA    = 2'd1;
   localparam logic [1:0] FRAME_DISPLAY = 2'd2;
   localparam logic [1:0] FRAME_DONE    = 2'd3;

   localparam logic [5:0] EDGE_STEPS = 6'd3;
   localparam logic [5:0] BYTE_STEPS = 6'd22;

   // sub-steps within one byte
   localparam logic [4:0] SUB_LOAD      = 5'd0;
   localparam logic [4:0] SUB_LAST_BIT  = 5'd16;
   localparam logic [4:0] SUB_CLK_LOW   = 5'd17;
   localparam logic [4:0] SUB_DATA_LOW  = 5'd18;
   localparam logic [4:0] SUB_CLK_HIGH  = 5'd19;
   localparam logic [4:0] SUB_CLK_LOW_2 = 5'd20;

endpackage

### rtl/ldtw_chan_if.sv
// Valid/ready channel interface for the two-wire LED driver writer.
// Carries one word of the given packed type; depends on nothing.
interface ldtw_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

### rtl/led_driver_two_wire_writer_top.sv
// Two-wire LED driver writer: tick-driven sequencer for clock and data pins.
// Depends on ldtw_pkg and ldtw_chan_if.
//
//   channel   dir  handshake        word
//   req_chan  in   valid/ready      mode, address, payload
//   rsp_chan  out  valid/ready      clock_pin, data_pin, busy_res, rejected
//   csr_*     in   APB write/read   short_wait, long_wait, mode/display command
//
// One word is accepted every cycle while rsp_chan is not stalled; its result
// passes the input register, then the sequencer update into the result register.
// Reset is synchronous; control and CSR registers reset, pins released.
// With rsp_chan.ready low the result holds and the input register absorbs
// one more word before req_chan.ready drops.
module led_driver_two_wire_writer_top #(
   parameter int unsigned WAIT_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   ldtw_chan_if.sink                               req_chan,
   ldtw_chan_if.source                             rsp_chan,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [ldtw_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [31:0]                             csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   localparam int unsigned WIDE_BITS = (WAIT_BITS > 8) ? WAIT_BITS : 8;
   localparam logic [WIDE_BITS-1:0] WAIT_LIMIT = WIDE_BITS'((64'd1 << WAIT_BITS) - 64'd1);

   logic [7:0] short_ff, long_ff, modecmd_ff, dispcmd_ff;
   logic [1:0] csr_index;
   logic       csr_write;

   ldtw_pkg::req_word_type in_word_ff;
   logic                   in_valid_ff;
   ldtw_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   rsp_valid_ff;
   logic                   accept, advance;

   logic [1:0]           frame_ff, frame_in;
   logic [5:0]           step_ff, step_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;
   logic [7:0]           addr_ff, addr_in, pay_ff, pay_in, shift_ff, shift_in;
   logic                 clk_ff, clk_in, dat_ff, dat_in, active_ff, active_in;

   // configuration
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         ldtw_pkg::REG_SHORT_WAIT:      csr_prdata = {24'd0, short_ff};
         ldtw_pkg::REG_LONG_WAIT:       csr_prdata = {24'd0, long_ff};
         ldtw_pkg::REG_MODE_COMMAND:    csr_prdata = {24'd0, modecmd_ff};
         ldtw_pkg::REG_DISPLAY_COMMAND: csr_prdata = {24'd0, dispcmd_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= ldtw_pkg::SHORT_WAIT_RESET;
         long_ff    <= ldtw_pkg::LONG_WAIT_RESET;
         modecmd_ff <= ldtw_pkg::MODE_COMMAND_RESET;
         dispcmd_ff <= ldtw_pkg::DISPLAY_COMMAND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ldtw_pkg::REG_SHORT_WAIT:      short_ff   <= csr_pwdata[7:0];
            ldtw_pkg::REG_LONG_WAIT:       long_ff    <= csr_pwdata[7:0];
            ldtw_pkg::REG_MODE_COMMAND:    modecmd_ff <= csr_pwdata[7:0];
            ldtw_pkg::REG_DISPLAY_COMMAND: dispcmd_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   // sequencer
   always_comb begin
      logic [5:0]           body;
      logic [5:0]           r;
      logic [5:0]           step_next;
      logic                 second;
      logic [4:0]           sub;
      logic [7:0]           w;
      logic [7:0]           v;
      logic [WIDE_BITS-1:0] v_wide;
      logic                 rej;

      frame_in  = frame_ff;
      step_in   = step_ff;
      wait_in   = wait_ff;
      addr_in   = addr_ff;
      pay_in    = pay_ff;
      shift_in  = shift_ff;
      clk_in    = clk_ff;
      dat_in    = dat_ff;
      active_in = active_ff;
      rej       = 1'b0;
      body      = (frame_ff == ldtw_pkg::FRAME_DATA) ? 6'(2 * ldtw_pkg::BYTE_STEPS)
                                                      : ldtw_pkg::BYTE_STEPS;
      r         = 6'(step_ff - ldtw_pkg::EDGE_STEPS);
      second    = (r >= ldtw_pkg::BYTE_STEPS);
      sub       = second ? 5'(r - ldtw_pkg::BYTE_STEPS) : 5'(r);
      step_next = 6'(step_ff + 6'd1);
      w         = 8'd0;
      v         = 8'd0;
      v_wide    = '0;

      if (in_word_ff.mode == ldtw_pkg::MODE_REQUEST) begin
         if (active_ff) begin
            rej = 1'b1;
         end else begin
            addr_in   = in_word_ff.address;
            pay_in    = in_word_ff.payload;
            frame_in  = ldtw_pkg::FRAME_MODE;
            step_in   = 6'd0;
            wait_in   = '0;
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         if (wait_ff != '0) begin
            wait_in = wait_ff - WAIT_BITS'(1);
            if (wait_in == '0 && frame_ff == ldtw_pkg::FRAME_DONE) begin
               frame_in  = ldtw_pkg::FRAME_MODE;
               step_in   = 6'd0;
               active_in = 1'b0;
            end
         end else if (frame_ff == ldtw_pkg::FRAME_DONE) begin
            frame_in  = ldtw_pkg::FRAME_MODE;
            step_in   = 6'd0;
            active_in = 1'b0;
         end else begin
            if (step_ff < ldtw_pkg::EDGE_STEPS) begin
               case (step_ff)
                  6'd0: begin
                     dat_in = 1'b1;
                     w = short_ff;
                  end
                  6'd1: begin
                     clk_in = 1'b1;
                     w = long_ff;
                  end
                  default: begin
                     dat_in = 1'b0;
                     w = long_ff;
                  end
               endcase
            end else if (step_ff < 6'(ldtw_pkg::EDGE_STEPS + body)) begin
               if (sub == ldtw_pkg::SUB_LOAD) begin
                  case (frame_ff)
                     ldtw_pkg::FRAME_MODE: shift_in = modecmd_ff;
                     ldtw_pkg::FRAME_DATA: shift_in = second ? pay_ff : addr_ff;
                     default:              shift_in = dispcmd_ff;
                  endcase
                  w = short_ff;
               end else if (sub <= ldtw_pkg::SUB_LAST_BIT) begin
                  if (sub[0]) begin
                     clk_in   = 1'b0;
                     dat_in   = shift_ff[0];
                     shift_in = {1'b0, shift_ff[7:1]};
                     w = short_ff;
                  end else begin
                     clk_in = 1'b1;
                     w = (sub < ldtw_pkg::SUB_LAST_BIT) ? short_ff : 8'd0;
                  end
               end else begin
                  case (sub)
                     ldtw_pkg::SUB_CLK_LOW: begin
                        clk_in = 1'b0;
                        w = short_ff;
                     end
                     ldtw_pkg::SUB_DATA_LOW: begin
                        dat_in = 1'b0;
                        w = short_ff;
                     end
                     ldtw_pkg::SUB_CLK_HIGH: begin
                        clk_in = 1'b1;
                        w = short_ff;
                     end
                     ldtw_pkg::SUB_CLK_LOW_2: begin
                        clk_in = 1'b0;
                        w = short_ff;
                     end
                     default: begin
                        dat_in = 1'b1;
                        w = 8'd0;
                     end
                  endcase
               end
            end else begin
               case (6'(step_ff - ldtw_pkg::EDGE_STEPS - body))
                  6'd0: begin
                     dat_in = 1'b0;
                     w = short_ff;
                  end
                  6'd1: begin
                     clk_in = 1'b1;
                     w = long_ff;
                  end
                  default: begin
                     dat_in = 1'b1;
                     w = long_ff;
                  end
               endcase
            end

            v       = (w == 8'd0) ? 8'd0 : 8'(w - 8'd1);
            v_wide  = WIDE_BITS'(v);
            wait_in = (v_wide > WAIT_LIMIT) ? WAIT_BITS'(WAIT_LIMIT) : WAIT_BITS'(v_wide);

            step_in = step_next;
            if (step_next >= 6'(2 * ldtw_pkg::EDGE_STEPS + body)) begin
               step_in  = 6'd0;
               frame_in = 2'(frame_ff + 2'd1);
            end
            if (frame_in == ldtw_pkg::FRAME_DONE && wait_in == '0) begin
               frame_in  = ldtw_pkg::FRAME_MODE;
               active_in = 1'b0;
            end
         end
      end

      rsp_word_in.clock_pin = clk_in;
      rsp_word_in.data_pin  = dat_in;
      rsp_word_in.busy_res  = active_in;
      rsp_word_in.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frame_ff     <= ldtw_pkg::FRAME_MODE;
         step_ff      <= 6'd0;
         wait_ff      <= '0;
         clk_ff       <= 1'b1;
         dat_ff       <= 1'b1;
         active_ff    <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            frame_ff  <= frame_in;
            step_ff   <= step_in;
            wait_ff   <= wait_in;
            clk_ff    <= clk_in;
            dat_ff    <= dat_in;
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_chan.word;
      end
      if (advance) begin
         addr_ff     <= addr_in;
         pay_ff      <= pay_in;
         shift_ff    <= shift_in;
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (frame_ff == ldtw_pkg::FRAME_MODE && step_ff == 6'd0 && wait_ff == '0))
      else $error("idle sequencer holds leftover frame, step or wait");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (active_ff && frame_ff == ldtw_pkg::FRAME_DONE) |-> (wait_ff != '0))
      else $error("finished sequence still marked busy with no wait left");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (frame_ff == ldtw_pkg::FRAME_DATA) ? (step_ff < 6'd50) : (step_ff < 6'd28))
      else $error("action step beyond frame length");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.rejected) |-> rsp_word_ff.busy_res)
      else $error("rejected request reported while idle");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.mode == ldtw_pkg::MODE_REQUEST && active_ff)
      |=> ($stable(frame_ff) && $stable(step_ff) && $stable(wait_ff)))
      else $error("rejected request disturbed the sequence");

endmodule

### tb/sv/led_driver_two_wire_writer_top_tb.sv
`timescale 1ns / 100ps
// Testbench for led_driver_two_wire_writer_top: directed table, then random phases.
// Pin levels are predicted per accepted word and checked in order on the result channel.
// Depends on ldtw_pkg, ldtw_chan_if and the block under test.
module led_driver_two_wire_writer_top_tb;

   localparam int unsigned CLK_PERIOD  = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                   typed;
      ldtw_pkg::req_word_type word;
      ldtw_pkg::rsp_word_type pins;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] short_w;
      logic [7:0] long_w;
      logic [7:0] mode_cmd;
      logic [7:0] disp_cmd;
   } wire_cfg_type;

   logic clock = 1'b0;
   logic reset;

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [ldtw_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ldtw_chan_if #(.word_type(ldtw_pkg::req_word_type)) req_chan ();
   ldtw_chan_if #(.word_type(ldtw_pkg::rsp_word_type)) rsp_chan ();

   led_driver_two_wire_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // pin sequencer state and its register copies
   logic [1:0] seq_frame;
   logic [5:0] seq_step;
   logic [7:0] hold_left;
   logic [7:0] latched_address;
   logic [7:0] latched_payload;
   logic [7:0] shift_reg;
   logic       pin_clock;
   logic       pin_data;
   logic       seq_busy;
   logic [7:0] short_ticks;
   logic [7:0] long_ticks;
   logic [7:0] mode_byte;
   logic [7:0] display_byte;

   ldtw_pkg::rsp_word_type pending_pins [$];
   directed_row_type       directed_rows [$];
   int unsigned            accepted_count = 0;
   int unsigned            failures = 0;
   int unsigned            burst_left = 0;
   int unsigned            cycle_count = 0;

   function automatic void reset_pin_state();
      seq_frame       = ldtw_pkg::FRAME_MODE;
      seq_step        = 6'd0;
      hold_left       = 8'd0;
      latched_address = 8'd0;
      latched_payload = 8'd0;
      shift_reg       = 8'd0;
      pin_clock       = 1'b1;
      pin_data        = 1'b1;
      seq_busy        = 1'b0;
      short_ticks     = ldtw_pkg::SHORT_WAIT_RESET;
      long_ticks      = ldtw_pkg::LONG_WAIT_RESET;
      mode_byte       = ldtw_pkg::MODE_COMMAND_RESET;
      display_byte    = ldtw_pkg::DISPLAY_COMMAND_RESET;
   endfunction

   function automatic void run_pin_action();
      int unsigned body;
      int unsigned pos;
      int unsigned sub;
      logic [7:0]  ticks;
      body  = (seq_frame == ldtw_pkg::FRAME_DATA) ? 2 * ldtw_pkg::BYTE_STEPS
                                                  : ldtw_pkg::BYTE_STEPS;
      ticks = 8'd0;
      if (seq_step < ldtw_pkg::EDGE_STEPS) begin
         case (seq_step)
            6'd0: begin
               pin_data = 1'b1;
               ticks    = short_ticks;
            end
            6'd1: begin
               pin_clock = 1'b1;
               ticks     = long_ticks;
            end
            default: begin
               pin_data = 1'b0;
               ticks    = long_ticks;
            end
         endcase
      end else if (seq_step < ldtw_pkg::EDGE_STEPS + body) begin
         pos = seq_step - ldtw_pkg::EDGE_STEPS;
         sub = pos % ldtw_pkg::BYTE_STEPS;
         if (sub == ldtw_pkg::SUB_LOAD) begin
            case (seq_frame)
               ldtw_pkg::FRAME_MODE: shift_reg = mode_byte;
               ldtw_pkg::FRAME_DATA:
                  shift_reg = (pos < ldtw_pkg::BYTE_STEPS) ? latched_address
                                                           : latched_payload;
               default:              shift_reg = display_byte;
            endcase
            ticks = short_ticks;
         end else if (sub <= ldtw_pkg::SUB_LAST_BIT) begin
            if (sub % 2 == 1) begin
               pin_clock = 1'b0;
               pin_data  = shift_reg[0];
               shift_reg = shift_reg >> 1;
               ticks     = short_ticks;
            end else begin
               pin_clock = 1'b1;
               ticks     = (sub < ldtw_pkg::SUB_LAST_BIT) ? short_ticks : 8'd0;
            end
         end else begin
            case (sub)
               ldtw_pkg::SUB_CLK_LOW: begin
                  pin_clock = 1'b0;
                  ticks     = short_ticks;
               end
               ldtw_pkg::SUB_DATA_LOW: begin
                  pin_data = 1'b0;
                  ticks    = short_ticks;
               end
               ldtw_pkg::SUB_CLK_HIGH: begin
                  pin_clock = 1'b1;
                  ticks     = short_ticks;
               end
               ldtw_pkg::SUB_CLK_LOW_2: begin
                  pin_clock = 1'b0;
                  ticks     = short_ticks;
               end
               default: begin
                  pin_data = 1'b1;
                  ticks    = 8'd0;
               end
            endcase
         end
      end else begin
         pos = seq_step - ldtw_pkg::EDGE_STEPS - body;
         case (pos)
            0: begin
               pin_data = 1'b0;
               ticks    = short_ticks;
            end
            1: begin
               pin_clock = 1'b1;
               ticks     = long_ticks;
            end
            default: begin
               pin_data = 1'b1;
               ticks    = long_ticks;
            end
         endcase
      end
      hold_left = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
      if (seq_step + 1 >= 2 * ldtw_pkg::EDGE_STEPS + body) begin
         seq_step  = 6'd0;
         seq_frame = seq_frame + 2'd1;
      end else begin
         seq_step = seq_step + 6'd1;
      end
      if (seq_frame == ldtw_pkg::FRAME_DONE && hold_left == 8'd0) begin
         seq_frame = ldtw_pkg::FRAME_MODE;
         seq_busy  = 1'b0;
      end
   endfunction

   function automatic ldtw_pkg::rsp_word_type next_pin_state(ldtw_pkg::req_word_type w);
      ldtw_pkg::rsp_word_type pins;
      pins.rejected = 1'b0;
      if (w.mode == ldtw_pkg::MODE_REQUEST) begin
         if (seq_busy) begin
            pins.rejected = 1'b1;
         end else begin
            latched_address = w.address;
            latched_payload = w.payload;
            seq_frame       = ldtw_pkg::FRAME_MODE;
            seq_step        = 6'd0;
            hold_left       = 8'd0;
            seq_busy        = 1'b1;
         end
      end else if (seq_busy) begin
         if (hold_left != 8'd0) begin
            hold_left = hold_left - 8'd1;
            if (hold_left == 8'd0 && seq_frame == ldtw_pkg::FRAME_DONE) begin
               seq_frame = ldtw_pkg::FRAME_MODE;
               seq_step  = 6'd0;
               seq_busy  = 1'b0;
            end
         end else if (seq_frame == ldtw_pkg::FRAME_DONE) begin
            seq_frame = ldtw_pkg::FRAME_MODE;
            seq_step  = 6'd0;
            seq_busy  = 1'b0;
         end else begin
            run_pin_action();
         end
      end
      pins.clock_pin = pin_clock;
      pins.data_pin  = pin_data;
      pins.busy_res  = seq_busy;
      return pins;
   endfunction

   task automatic check_pin(string field, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s expected %0b got %0b", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      ldtw_pkg::rsp_word_type want;
      ldtw_pkg::rsp_word_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want = next_pin_state(req_chan.word);
            if (accepted_count < directed_rows.size() && directed_rows[accepted_count].typed)
               want = directed_rows[accepted_count].pins;
            pending_pins.push_back(want);
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.word;
            if (pending_pins.size() == 0) begin
               $display("%0t: word with none expected, got %b", $time, got);
               failures++;
            end else begin
               want = pending_pins.pop_front();
               check_pin("clock_pin", want.clock_pin, got.clock_pin);
               check_pin("data_pin", want.data_pin, got.data_pin);
               check_pin("busy_res", want.busy_res, got.busy_res);
               check_pin("rejected", want.rejected, got.rejected);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: stall on a 32-bit ready pattern, reloaded with a new density each pass
   initial begin : result_sink
      logic [31:0] ready_pattern;
      int unsigned pattern_pos;
      rsp_chan.ready <= 1'b0;
      ready_pattern = '1;
      pattern_pos   = 0;
      forever begin
         @(posedge clock);
         if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern = '1;
               1:       ready_pattern = $urandom;
               2:       ready_pattern = $urandom & $urandom;
               default: ready_pattern = $urandom | $urandom;
            endcase
         end
         rsp_chan.ready <= ready_pattern[pattern_pos];
         pattern_pos = (pattern_pos + 1) % 32;
      end
   end

   task automatic add_row(logic typed, logic mode, logic [7:0] address, logic [7:0] payload,
                          logic [3:0] pins);
      directed_row_type row;
      row.typed = typed;
      row.word  = {mode, address, payload};
      row.pins  = pins;
      directed_rows.push_back(row);
   endtask

   task automatic send_word(ldtw_pkg::req_word_type w);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.word  <= w;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_pins.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         ldtw_pkg::REG_SHORT_WAIT:      short_ticks  = value;
         ldtw_pkg::REG_LONG_WAIT:       long_ticks   = value;
         ldtw_pkg::REG_MODE_COMMAND:    mode_byte    = value;
         ldtw_pkg::REG_DISPLAY_COMMAND: display_byte = value;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      wire_cfg_type           cfg;
      ldtw_pkg::req_word_type w;
      int unsigned            items;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.word  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      reset_pin_state();

      //       typed mode                    addr   data   clk,dat,busy,rej
      add_row(1'b1, ldtw_pkg::MODE_TICK,    8'h00, 8'h00, 4'b1100);
      add_row(1'b1, ldtw_pkg::MODE_TICK,    8'hFF, 8'hFF, 4'b1100);
      add_row(1'b1, ldtw_pkg::MODE_REQUEST, 8'h00, 8'hFF, 4'b1110);
      add_row(1'b1, ldtw_pkg::MODE_REQUEST, 8'hFF, 8'h00, 4'b1111);
      add_row(1'b0, ldtw_pkg::MODE_TICK,    8'h00, 8'h00, 4'b0000);
      add_row(1'b0, ldtw_pkg::MODE_TICK,    8'hFF, 8'hFF, 4'b0000);
      add_row(1'b1, ldtw_pkg::MODE_REQUEST, 8'hA5, 8'h5A, 4'b1111);
      for (int i = 0; i < 15; i++)
         add_row(1'b0, (i == 12) ? ldtw_pkg::MODE_REQUEST : ldtw_pkg::MODE_TICK,
                 8'h3C, 8'hC3, 4'b0000);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i].word);

      for (int phase = 0; phase < 8; phase++) begin
         items = 100;
         case (phase)
            0: cfg = {8'd1, 8'd1, 8'($urandom), 8'($urandom)};
            1: cfg = {8'd0, 8'd0, 8'h00, 8'hFF};
            2: cfg = {8'd2, 8'd1, 8'hFF, 8'h00};
            3: cfg = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom), 8'($urandom)};
            4: begin
               cfg   = {8'd1, 8'd255, 8'($urandom), 8'($urandom)};
               items = 150;
            end
            5: begin
               cfg   = {8'd255, 8'd0, 8'($urandom), 8'($urandom)};
               items = 120;
            end
            6: begin
               cfg   = {8'd0, 8'd1, 8'($urandom), 8'($urandom)};
               items = 140;
            end
            default: begin
               cfg   = {ldtw_pkg::SHORT_WAIT_RESET, ldtw_pkg::LONG_WAIT_RESET,
                        ldtw_pkg::MODE_COMMAND_RESET, ldtw_pkg::DISPLAY_COMMAND_RESET};
               items = 140;
            end
         endcase
         drain_results();
         csr_write(ldtw_pkg::REG_SHORT_WAIT, cfg.short_w);
         csr_write(ldtw_pkg::REG_LONG_WAIT, cfg.long_w);
         csr_write(ldtw_pkg::REG_MODE_COMMAND, cfg.mode_cmd);
         csr_write(ldtw_pkg::REG_DISPLAY_COMMAND, cfg.disp_cmd);
         for (int n = 0; n < items; n++) begin
            w.mode    = ($urandom_range(0, 19) == 0) ? ldtw_pkg::MODE_REQUEST
                                                     : ldtw_pkg::MODE_TICK;
            w.address = 8'($urandom_range(0, 255));
            w.payload = 8'($urandom_range(0, 255));
            send_word(w);
            if (phase == 3 && n == 50) drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### files.f
rtl/ldtw_pkg.sv
rtl/ldtw_chan_if.sv
rtl/led_driver_two_wire_writer_top.sv
tb/sv/led_driver_two_wire_writer_top_tb.sv
